>>> hdl/mi3_pkg.sv
// shared types and constants for the 3x3 matrix inverse pipeline
package mi3_pkg;

    // element width, fixed by the payload fields
    localparam int EW  = 32;
    // exact cofactor width: difference of two element products
    localparam int AW  = 2 * EW + 1;
    // exact determinant width: sum of three element times cofactor products
    localparam int DW  = 3 * EW + 2;
    // number of matrix elements
    localparam int NEL = 9;

    // input beat: one matrix, row major
    typedef struct packed {
        logic signed [EW-1:0] m00;
        logic signed [EW-1:0] m01;
        logic signed [EW-1:0] m02;
        logic signed [EW-1:0] m10;
        logic signed [EW-1:0] m11;
        logic signed [EW-1:0] m12;
        logic signed [EW-1:0] m20;
        logic signed [EW-1:0] m21;
        logic signed [EW-1:0] m22;
    } mi3_mat_t;

    // output beat: inverse, row major, plus status
    typedef struct packed {
        logic signed [EW-1:0] r00;
        logic signed [EW-1:0] r01;
        logic signed [EW-1:0] r02;
        logic signed [EW-1:0] r10;
        logic signed [EW-1:0] r11;
        logic signed [EW-1:0] r12;
        logic signed [EW-1:0] r20;
        logic signed [EW-1:0] r21;
        logic signed [EW-1:0] r22;
        logic                 singular;
        logic                 overflow;
    } mi3_inv_t;

    // adjugate in row major order plus the first matrix row
    typedef struct packed {
        logic [NEL-1:0][AW-1:0] adj;
        logic [2:0][EW-1:0]     row;
    } mi3_cof_t;

    // adjugate plus determinant
    typedef struct packed {
        logic [NEL-1:0][AW-1:0] adj;
        logic [DW-1:0]          det;
    } mi3_det_t;

endpackage

>>> hdl/mi3_cof.sv
// adjugate stages: cofactor products, then differences
module mi3_cof
    import mi3_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     up_valid,
    output logic     up_ready,
    input  mi3_mat_t up_data,
    output logic     dn_valid,
    input  logic     dn_ready,
    output mi3_cof_t dn_data
);

    localparam int PW = 2 * EW;

    // adj[k] = el[X1]*el[Y1] - el[X2]*el[Y2], elements row major
    localparam logic [3:0] X1 [NEL] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam logic [3:0] Y1 [NEL] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam logic [3:0] X2 [NEL] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam logic [3:0] Y2 [NEL] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    logic signed [EW-1:0]   el [NEL];
    logic signed [PW-1:0]   pa_reg [NEL];
    logic signed [PW-1:0]   pb_reg [NEL];
    logic [2:0][EW-1:0]     row1_reg;
    logic [2:0][EW-1:0]     row2_reg;
    logic [NEL-1:0][AW-1:0] adj_reg;
    logic [1:0]             v_reg;
    logic                   en1;
    logic                   en2;

    // unpack the matrix beat
    assign el[0] = up_data.m00;
    assign el[1] = up_data.m01;
    assign el[2] = up_data.m02;
    assign el[3] = up_data.m10;
    assign el[4] = up_data.m11;
    assign el[5] = up_data.m12;
    assign el[6] = up_data.m20;
    assign el[7] = up_data.m21;
    assign el[8] = up_data.m22;

    // stage advance, bubbles collapse
    assign en2      = ~v_reg[1] | dn_ready;
    assign en1      = ~v_reg[0] | en2;
    assign up_ready = en1;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en1)
            begin
                v_reg[0] <= up_valid;
            end
            if (en2)
            begin
                v_reg[1] <= v_reg[0];
            end
        end
    end

    // stage 1: eighteen element products
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            for (int k = 0; k < NEL; k++)
            begin
                pa_reg[k] <= el[X1[k]] * el[Y1[k]];
                pb_reg[k] <= el[X2[k]] * el[Y2[k]];
            end
            row1_reg[0] <= up_data.m00;
            row1_reg[1] <= up_data.m01;
            row1_reg[2] <= up_data.m02;
        end
    end

    // stage 2: cofactor differences
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            for (int k = 0; k < NEL; k++)
            begin
                adj_reg[k] <= AW'(pa_reg[k]) - AW'(pb_reg[k]);
            end
            row2_reg <= row1_reg;
        end
    end

    assign dn_valid    = v_reg[1];
    assign dn_data.adj = adj_reg;
    assign dn_data.row = row2_reg;

endmodule

>>> hdl/mi3_det.sv
// determinant stages: first row expansion with split multiplies
module mi3_det
    import mi3_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     up_valid,
    output logic     up_ready,
    input  mi3_cof_t up_data,
    output logic     dn_valid,
    input  logic     dn_ready,
    output mi3_det_t dn_data
);

    // cofactor that pairs with each first row element
    localparam logic [3:0] COL [3] = '{4'd0, 4'd3, 4'd6};

    logic signed [EW-1:0]   rw [3];
    logic signed [2*EW:0]   lo_reg [3];
    logic signed [2*EW:0]   hi_reg [3];
    logic signed [DW-1:0]   pr_reg [3];
    logic signed [DW-1:0]   det_reg;
    logic [NEL-1:0][AW-1:0] adj3_reg;
    logic [NEL-1:0][AW-1:0] adj4_reg;
    logic [NEL-1:0][AW-1:0] adj5_reg;
    logic [2:0]             v_reg;
    logic [3:0]             en;

    assign rw[0] = up_data.row[0];
    assign rw[1] = up_data.row[1];
    assign rw[2] = up_data.row[2];

    // stage advance
    assign en[3]    = dn_ready;
    assign en[2]    = ~v_reg[2] | en[3];
    assign en[1]    = ~v_reg[1] | en[2];
    assign en[0]    = ~v_reg[0] | en[1];
    assign up_ready = en[0];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= up_valid;
            end
            if (en[1])
            begin
                v_reg[1] <= v_reg[0];
            end
            if (en[2])
            begin
                v_reg[2] <= v_reg[1];
            end
        end
    end

    // stage 3: element times low and high halves of the cofactor
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int j = 0; j < 3; j++)
            begin
                lo_reg[j] <= rw[j] * $signed({1'b0, up_data.adj[COL[j]][EW-1:0]});
                hi_reg[j] <= rw[j] * $signed(up_data.adj[COL[j]][AW-1:EW]);
            end
            adj3_reg <= up_data.adj;
        end
    end

    // stage 4: recombine halves
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int j = 0; j < 3; j++)
            begin
                pr_reg[j] <= (DW'(hi_reg[j]) <<< EW) + DW'(lo_reg[j]);
            end
            adj4_reg <= adj3_reg;
        end
    end

    // stage 5: sum of the three terms
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            det_reg  <= pr_reg[0] + pr_reg[1] + pr_reg[2];
            adj5_reg <= adj4_reg;
        end
    end

    assign dn_valid    = v_reg[2];
    assign dn_data.adj = adj5_reg;
    assign dn_data.det = det_reg;

endmodule

>>> hdl/mi3_div.sv
// nine lane pipelined restoring divider with saturation and output register
module mi3_div
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     up_valid,
    output logic     up_ready,
    input  mi3_det_t up_data,
    output logic     dn_valid,
    input  logic     dn_ready,
    output mi3_inv_t dn_data
);

    // quotient bits kept: one above the element range for saturation
    localparam int QB = EW + 1;
    localparam int NW = AW + 2 * FRAC_BITS;
    localparam int TW = NW - QB;
    localparam int NS = QB + 3;
    localparam logic [QB-1:0] HALF = QB'(1) << (EW - 1);
    localparam logic [EW-1:0] MINV = EW'(1) << (EW - 1);
    localparam logic [EW-1:0] MAXV = ~MINV;

    logic [AW-1:0]  nm_reg [NEL];
    logic [NEL-1:0] sn_reg;
    logic [DW-1:0]  dm1_reg;
    logic           zr1_reg;

    logic [DW-1:0]  rem_reg [QB+1][NEL];
    logic [QB-1:0]  ql_reg  [QB+1][NEL];
    logic [NEL-1:0] big_reg [QB+1];
    logic [NEL-1:0] neg_reg [QB+1];
    logic [DW-1:0]  dm_reg  [QB+1];
    logic           zr_reg  [QB+1];

    logic [NW-1:0]  num [NEL];
    logic [TW-1:0]  top [NEL];
    logic [EW-1:0]  res [NEL];
    logic           ov_any;
    mi3_inv_t       inv_reg;

    logic [NS-1:0]  v_reg;
    logic [NS:0]    en;

    // stage advance, bubbles collapse
    assign en[NS] = dn_ready;
    for (genvar s = 0; s < NS; s++)
    begin : g_en
        assign en[s] = ~v_reg[s] | en[s+1];
    end
    assign up_ready = en[0];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= up_valid;
            end
            for (int s = 1; s < NS; s++)
            begin
                if (en[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    // magnitudes, result signs, zero determinant
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int l = 0; l < NEL; l++)
            begin
                nm_reg[l] <= up_data.adj[l][AW-1] ? (~up_data.adj[l] + AW'(1)) : up_data.adj[l];
                sn_reg[l] <= up_data.adj[l][AW-1] ^ up_data.det[DW-1];
            end
            dm1_reg <= up_data.det[DW-1] ? (~up_data.det + DW'(1)) : up_data.det;
            zr1_reg <= (up_data.det == '0);
        end
    end

    // scaled numerator and its part above the kept quotient bits
    always_comb
    begin
        for (int l = 0; l < NEL; l++)
        begin
            num[l] = {nm_reg[l], (2 * FRAC_BITS)'(0)};
            top[l] = num[l][NW-1:QB];
        end
    end

    // quotient too large for the kept bits, and the starting remainder
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int l = 0; l < NEL; l++)
            begin
                rem_reg[0][l] <= DW'(top[l]);
                ql_reg[0][l]  <= num[l][QB-1:0];
                big_reg[0][l] <= DW'(top[l]) >= dm1_reg;
            end
            neg_reg[0] <= sn_reg;
            dm_reg[0]  <= dm1_reg;
            zr_reg[0]  <= zr1_reg;
        end
    end

    // one quotient bit per stage and lane
    for (genvar j = 1; j <= QB; j++)
    begin : g_step
        logic [DW:0]   tr [NEL];
        logic [DW+1:0] df [NEL];

        always_comb
        begin
            for (int l = 0; l < NEL; l++)
            begin
                tr[l] = {rem_reg[j-1][l], ql_reg[j-1][l][QB-1]};
                df[l] = {1'b0, tr[l]} - {2'b00, dm_reg[j-1]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[j+1])
            begin
                for (int l = 0; l < NEL; l++)
                begin
                    rem_reg[j][l] <= df[l][DW+1] ? tr[l][DW-1:0] : df[l][DW-1:0];
                    ql_reg[j][l]  <= {ql_reg[j-1][l][QB-2:0], ~df[l][DW+1]};
                end
                big_reg[j] <= big_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                dm_reg[j]  <= dm_reg[j-1];
                zr_reg[j]  <= zr_reg[j-1];
            end
        end
    end

    // sign and saturation, or a zero result when the determinant is zero
    always_comb
    begin
        ov_any = 1'b0;
        for (int l = 0; l < NEL; l++)
        begin
            if (zr_reg[QB])
            begin
                res[l] = '0;
            end
            else if (neg_reg[QB][l])
            begin
                if (big_reg[QB][l] || (ql_reg[QB][l] > HALF))
                begin
                    res[l] = MINV;
                    ov_any = 1'b1;
                end
                else
                begin
                    res[l] = ~ql_reg[QB][l][EW-1:0] + EW'(1);
                end
            end
            else
            begin
                if (big_reg[QB][l] || (ql_reg[QB][l] > (HALF - QB'(1))))
                begin
                    res[l] = MAXV;
                    ov_any = 1'b1;
                end
                else
                begin
                    res[l] = ql_reg[QB][l][EW-1:0];
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            inv_reg.r00      <= res[0];
            inv_reg.r01      <= res[1];
            inv_reg.r02      <= res[2];
            inv_reg.r10      <= res[3];
            inv_reg.r11      <= res[4];
            inv_reg.r12      <= res[5];
            inv_reg.r20      <= res[6];
            inv_reg.r21      <= res[7];
            inv_reg.r22      <= res[8];
            inv_reg.singular <= zr_reg[QB];
            inv_reg.overflow <= ov_any;
        end
    end

    assign dn_valid = v_reg[NS-1];
    assign dn_data  = inv_reg;

endmodule

>>> hdl/matrix_inverse_3x3.sv
// throughput: one matrix per cycle with inv_ready high; one bit per divider stage
// every stage advances when it is empty or the next one moves, so bubbles collapse
// reset clears the valid bits only; no other state
// top level: 3x3 matrix inverse by adjugate over determinant
module matrix_inverse_3x3
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     mat_valid,
    output logic     mat_ready,
    input  mi3_mat_t mat,
    output logic     inv_valid,
    input  logic     inv_ready,
    output mi3_inv_t inv
);

    logic     cof_valid;
    logic     cof_ready;
    mi3_cof_t cof_data;
    logic     det_valid;
    logic     det_ready;
    mi3_det_t det_data;

    // adjugate
    mi3_cof u_cof
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (mat_valid),
        .up_ready (mat_ready),
        .up_data  (mat),
        .dn_valid (cof_valid),
        .dn_ready (cof_ready),
        .dn_data  (cof_data)
    );

    // determinant
    mi3_det u_det
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (cof_valid),
        .up_ready (cof_ready),
        .up_data  (cof_data),
        .dn_valid (det_valid),
        .dn_ready (det_ready),
        .dn_data  (det_data)
    );

    // division and saturation
    mi3_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (det_valid),
        .up_ready (det_ready),
        .up_data  (det_data),
        .dn_valid (inv_valid),
        .dn_ready (inv_ready),
        .dn_data  (inv)
    );

endmodule

>>> tb/sv/tb_matrix_inverse_3x3.sv
// self-checking testbench for the 3x3 matrix inverse pipeline
module tb_matrix_inverse_3x3;
    import mi3_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC     = 16;
    localparam int LATENCY  = EW + 9;
    localparam int N_RANDOM = 1130;
    localparam int STALL_LIMIT = 2000;
    localparam logic signed [EW-1:0] ONE = 32'sh0001_0000;
    localparam logic signed [EW-1:0] MAXC = 32'sh7fff_ffff;
    localparam logic signed [EW-1:0] MINC = 32'sh8000_0000;

    typedef logic signed [191:0] wide_t;

    logic     clk;
    logic     rst_n;
    logic     mat_valid;
    logic     mat_ready;
    mi3_mat_t mat;
    logic     inv_valid;
    logic     inv_ready;
    mi3_inv_t inv;

    mi3_mat_t matrix_q[$];
    mi3_inv_t inverse_q[$];
    int       mismatches;
    int       beats_out;
    int       idle_cycles;
    bit       stim_done;

    matrix_inverse_3x3 #(.FRAC_BITS(FRAC)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat_valid (mat_valid),
        .mat_ready (mat_ready),
        .mat       (mat),
        .inv_valid (inv_valid),
        .inv_ready (inv_ready),
        .inv       (inv)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one inverse element: trunc(adj * 2^2F / det), saturated
    function automatic logic [EW-1:0] quot_elem(input wide_t adj, input wide_t det,
                                               inout bit ovf);
        logic  neg;
        wide_t n;
        wide_t d;
        wide_t q;
        neg = (adj < 0) != (det < 0);
        n = (adj < 0) ? -adj : adj;
        d = (det < 0) ? -det : det;
        n = n <<< (2 * FRAC);
        q = $unsigned(n) / $unsigned(d);
        if (neg)
        begin
            if (q > 192'sh8000_0000)
            begin
                ovf = 1'b1;
                return MINC;
            end
            return -q[EW-1:0];
        end
        if (q > 192'sh7fff_ffff)
        begin
            ovf = 1'b1;
            return MAXC;
        end
        return q[EW-1:0];
    endfunction

    // expected inverse of one matrix by adjugate over determinant
    function automatic mi3_inv_t invert(input mi3_mat_t m);
        wide_t    a, b, c, d, e, f, g, h, i;
        wide_t    adj[9];
        wide_t    det;
        bit       ovf;
        mi3_inv_t r;
        a = m.m00; b = m.m01; c = m.m02;
        d = m.m10; e = m.m11; f = m.m12;
        g = m.m20; h = m.m21; i = m.m22;
        ovf = 1'b0;
        adj[0] = e * i - f * h;
        adj[1] = c * h - b * i;
        adj[2] = b * f - c * e;
        adj[3] = f * g - d * i;
        adj[4] = a * i - c * g;
        adj[5] = c * d - a * f;
        adj[6] = d * h - e * g;
        adj[7] = b * g - a * h;
        adj[8] = a * e - b * d;
        det = a * adj[0] + b * adj[3] + c * adj[6];
        r = '0;
        if (det == 0)
        begin
            r.singular = 1'b1;
            return r;
        end
        r.r00 = quot_elem(adj[0], det, ovf);
        r.r01 = quot_elem(adj[1], det, ovf);
        r.r02 = quot_elem(adj[2], det, ovf);
        r.r10 = quot_elem(adj[3], det, ovf);
        r.r11 = quot_elem(adj[4], det, ovf);
        r.r12 = quot_elem(adj[5], det, ovf);
        r.r20 = quot_elem(adj[6], det, ovf);
        r.r21 = quot_elem(adj[7], det, ovf);
        r.r22 = quot_elem(adj[8], det, ovf);
        r.overflow = ovf;
        return r;
    endfunction

    function automatic mi3_mat_t mk(input logic [EW-1:0] a, b, c, d, e, f, g, h, i);
        mi3_mat_t m;
        m = {a, b, c, d, e, f, g, h, i};
        return m;
    endfunction

    // element within +/- span raw codes
    function automatic logic [EW-1:0] near_elem(input int unsigned span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // random matrix, drawn from several shapes
    function automatic mi3_mat_t rand_matrix();
        mi3_mat_t m;
        int       shape;
        int       k;
        shape = $urandom_range(0, 9);
        for (k = 0; k < NEL; k++)
        begin
            case (shape)
                0, 1:    m[k*EW +: EW] = $urandom();
                2, 3, 4: m[k*EW +: EW] = near_elem(32'h0004_0000);
                5:       m[k*EW +: EW] = near_elem(32'h0000_0400);
                6:       m[k*EW +: EW] = near_elem(8);
                default: m[k*EW +: EW] = near_elem(32'h0100_0000);
            endcase
        end
        // singular by a repeated or negated row
        if (shape == 8)
        begin
            m.m20 = m.m00; m.m21 = m.m01; m.m22 = m.m02;
        end
        if (shape == 9)
        begin
            m.m10 = -m.m00; m.m11 = -m.m01; m.m12 = -m.m02;
        end
        return m;
    endfunction

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        stim_done = 1'b0;
        // identity, zero, scaled, extremes, sign cases, singular
        matrix_q.push_back(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
        matrix_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        matrix_q.push_back(mk(2*ONE, 0, 0, 0, -4*ONE, 0, 0, 0, ONE/2));
        matrix_q.push_back(mk(MAXC, 0, 0, 0, MAXC, 0, 0, 0, MAXC));
        matrix_q.push_back(mk(MINC, 0, 0, 0, MINC, 0, 0, 0, MINC));
        matrix_q.push_back(mk(MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC));
        matrix_q.push_back(mk(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
        matrix_q.push_back(mk(1, 0, 0, 0, 1, 0, 0, 0, 1));
        matrix_q.push_back(mk(-1, 0, 0, 0, 1, 0, 0, 0, 1));
        matrix_q.push_back(mk(0, ONE, 0, ONE, 0, 0, 0, 0, ONE));
        matrix_q.push_back(mk(0, 0, ONE, 0, ONE, 0, ONE, 0, 0));
        matrix_q.push_back(mk(ONE, 2*ONE, 3*ONE, 4*ONE, 5*ONE, 6*ONE, 7*ONE, 8*ONE, 9*ONE));
        matrix_q.push_back(mk(ONE, 2*ONE, 3*ONE, 0, ONE, 4*ONE, 5*ONE, 6*ONE, 0));
        matrix_q.push_back(mk(ONE, ONE, 0, ONE, ONE, 0, 0, 0, ONE));
        matrix_q.push_back(mk(ONE, 1, 0, 0, ONE, 0, 0, 0, ONE));
        matrix_q.push_back(mk(32'hffff_ffff, 32'haaaa_aaaa, 32'h5555_5555, 32'h0f0f_0f0f,
                              32'hf0f0_f0f0, 32'h1234_5678, 32'h8765_4321, 1, 32'h7ffe_0001));
        matrix_q.push_back(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, 32'sh0000_8000));
        matrix_q.push_back(mk(-ONE, 0, 0, 0, ONE, 0, 0, 0, 32'sh0000_8000));
        matrix_q.push_back(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, -32'sh0000_8000));
        matrix_q.push_back(mk(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
        repeat (N_RANDOM) matrix_q.push_back(rand_matrix());
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait (matrix_q.size() == 0 && !mat_valid);
        wait (inverse_q.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        stim_done = 1'b1;
        if (mismatches == 0)
            $display("matrix_inverse_3x3 regression: pass");
        else
            $display("matrix_inverse_3x3 regression: fail");
        $finish;
    end

    // driver: matrix beats with random gaps, sometimes back to back
    int send_gap;
    int sent;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_valid <= 1'b0;
            mat       <= '0;
            send_gap  <= 0;
            sent      <= 0;
        end
        else if (!mat_valid || mat_ready)
        begin
            if (mat_valid)
                inverse_q.push_back(invert(mat));
            if (send_gap != 0)
            begin
                send_gap  <= send_gap - 1;
                mat_valid <= 1'b0;
            end
            else if (matrix_q.size() != 0)
            begin
                mat_valid <= 1'b1;
                mat       <= matrix_q.pop_front();
                sent      <= sent + 1;
                send_gap  <= ((sent / 100) % 3 == 1) ? 0 : $urandom_range(0, 7);
            end
            else
                mat_valid <= 1'b0;
        end
    end

    // monitor: random back pressure, one long hold-off, field by field check
    int hold;
    bit long_done;
    always @(posedge clk or negedge rst_n)
    begin
        logic [EW-1:0] got_f;
        logic [EW-1:0] exp_f;
        mi3_inv_t      want;
        if (!rst_n)
        begin
            inv_ready  <= 1'b0;
            hold       <= 0;
            long_done  <= 1'b0;
            mismatches <= 0;
            beats_out  <= 0;
        end
        else
        begin
            if (inv_valid && inv_ready)
            begin
                beats_out <= beats_out + 1;
                if (inverse_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected inverse beat %h", inv);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = inverse_q.pop_front();
                    if (want !== inv)
                    begin
                        if (mismatches < 10)
                        begin
                            for (int k = 0; k < NEL; k++)
                            begin
                                exp_f = want[2 + (8-k)*EW +: EW];
                                got_f = inv[2 + (8-k)*EW +: EW];
                                if (exp_f !== got_f)
                                    $display("beat %0d r%0d%0d: expected %h got %h",
                                             beats_out, k / 3, k % 3, exp_f, got_f);
                            end
                            if (want.singular !== inv.singular)
                                $display("beat %0d singular: expected %b got %b",
                                         beats_out, want.singular, inv.singular);
                            if (want.overflow !== inv.overflow)
                                $display("beat %0d overflow: expected %b got %b",
                                         beats_out, want.overflow, inv.overflow);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            // ready pattern for the next cycles
            if (hold != 0)
            begin
                hold      <= hold - 1;
                inv_ready <= 1'b0;
            end
            else if (inv_valid && inv_ready)
            begin
                if (!long_done && beats_out == 300)
                begin
                    long_done <= 1'b1;
                    hold      <= 8 * LATENCY;
                    inv_ready <= 1'b0;
                end
                else if ((beats_out / 128) % 3 == 2)
                    inv_ready <= 1'b1;
                else
                begin
                    hold      <= $urandom_range(0, 7);
                    inv_ready <= 1'b0;
                end
            end
            else
                inv_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (mat_valid && mat_ready) || (inv_valid && inv_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && !stim_done)
        begin
            $display("matrix_inverse_3x3 regression: fail");
            $finish;
        end
    end

endmodule
